[sv/srst_pkg.sv]
// ----------------------------------------------------------------------------
// srst_pkg
// Shared constants, zone codes and register indexes of the sweeping range
// scan tracker.
// ----------------------------------------------------------------------------
package srst_pkg;

  // default build parameters
  localparam int ANGLE_STEP_DEF = 10;
  localparam int SLOT_COUNT_DEF = 19;

  // field widths
  localparam int ANGLE_W = 8;
  localparam int RANGE_W = 8;
  localparam int TRANGE_W = 6;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 8;

  // decision thresholds
  localparam logic [RANGE_W-1:0] NEAR_LIMIT = 8'd50;
  localparam logic [RANGE_W-1:0] CLOSE_LIMIT = 8'd20;
  localparam logic [RANGE_W-1:0] NO_READING = 8'hff;
  localparam int LEFT_EDGE = 150;
  localparam int RIGHT_EDGE = 30;
  localparam int HOME_ANGLE = 90;

  typedef enum logic [1:0] {
    ZONE_FULL  = 2'd0,
    ZONE_LEFT  = 2'd1,
    ZONE_RIGHT = 2'd2,
    ZONE_FRONT = 2'd3
  } zone_t;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MIN  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MAX  = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MIN  = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_MAX  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MIN = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_MAX = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_MIN = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FRONT_MAX = 4'd7;

  // window bounds after reset
  localparam logic [ANGLE_W-1:0] FULL_MIN_RST  = 8'd0;
  localparam logic [ANGLE_W-1:0] FULL_MAX_RST  = 8'd180;
  localparam logic [ANGLE_W-1:0] LEFT_MIN_RST  = 8'd120;
  localparam logic [ANGLE_W-1:0] LEFT_MAX_RST  = 8'd180;
  localparam logic [ANGLE_W-1:0] RIGHT_MIN_RST = 8'd0;
  localparam logic [ANGLE_W-1:0] RIGHT_MAX_RST = 8'd60;
  localparam logic [ANGLE_W-1:0] FRONT_MIN_RST = 8'd30;
  localparam logic [ANGLE_W-1:0] FRONT_MAX_RST = 8'd150;

endpackage

[sv/srst_if.sv]
// ----------------------------------------------------------------------------
// srst channel interfaces
// Valid/ready channels for range readings, tracker results and register
// writes.
// ----------------------------------------------------------------------------
interface srst_range_if;
  import srst_pkg::*;
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] range_cm;

  modport source (output valid, output range_cm, input ready);
  modport sink   (input valid, input range_cm, output ready);
endinterface

interface srst_result_if;
  import srst_pkg::*;
  logic                valid;
  logic                ready;
  logic [ANGLE_W-1:0]  servo_angle;
  logic                target_found;
  logic [ANGLE_W-1:0]  target_angle;
  logic [TRANGE_W-1:0] target_range;
  logic [1:0]          zone_code;
  logic                sweep_up;

  modport source (output valid, output servo_angle, output target_found,
                  output target_angle, output target_range, output zone_code,
                  output sweep_up, input ready);
  modport sink   (input valid, input servo_angle, input target_found,
                  input target_angle, input target_range, input zone_code,
                  input sweep_up, output ready);
endinterface

interface srst_cfg_if;
  import srst_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[sv/srst_ram.sv]
// ----------------------------------------------------------------------------
// srst_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module srst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 19
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/sweeping_range_scan_tracker_top.sv]
// ----------------------------------------------------------------------------
// sweeping_range_scan_tracker_top
// Range scan tracker: stores readings per slot angle, finds the nearest
// target, picks a sweep window and steps the servo angle.
//
// channel     dir  handshake      payload
// range_in    in   valid/ready    range_cm
// result_out  out  valid/ready    servo_angle, target_found, target_angle,
//                                 target_range, zone_code, sweep_up
// cfg         in   valid/ready    index, data (ready always high)
//
// in a transaction the slot memory is walked one entry a cycle through its
// single read port for the minimum search, then the target is evaluated and
// the window applied.
// slot readings live in a RAM, with one valid bit per slot; reset clears the
// valid bits at once, so no clearing pass is needed.
// the next reading is taken while a result still waits in the output
// register; the block holds in its last step only if that register is full.
// ----------------------------------------------------------------------------
module sweeping_range_scan_tracker_top #(
  parameter int ANGLE_STEP = srst_pkg::ANGLE_STEP_DEF,
  parameter int SLOT_COUNT = srst_pkg::SLOT_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  srst_range_if.sink    range_in,
  srst_result_if.source result_out,
  srst_cfg_if.sink      cfg
);
  import srst_pkg::*;

  localparam int SW = $clog2(SLOT_COUNT);
  localparam int RW = (ANGLE_STEP > 1) ? $clog2(ANGLE_STEP) : 1;
  localparam int TAW_RAW = $clog2((SLOT_COUNT - 1) * ANGLE_STEP + 1);
  localparam int TAW = (TAW_RAW > ANGLE_W) ? TAW_RAW : ANGLE_W;
  localparam int ANGLE_TOP = (1 << ANGLE_W) - 1;
  localparam logic [RW-1:0] REM_LAST = RW'(ANGLE_STEP - 1);
  localparam logic [RW-1:0] REM_HOME = RW'(HOME_ANGLE % ANGLE_STEP);
  localparam logic [ANGLE_W-1:0] IDX_HOME = ANGLE_W'(HOME_ANGLE / ANGLE_STEP);
  localparam logic [RW-1:0] REM_TOP = RW'(ANGLE_TOP % ANGLE_STEP);
  localparam logic [ANGLE_W-1:0] IDX_TOP = ANGLE_W'(ANGLE_TOP / ANGLE_STEP);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_LAST = 5'b00100,
    S_EVAL = 5'b01000,
    S_MOVE = 5'b10000
  } state_t;

  state_t state;

  // window bounds, one pair per zone
  logic [ANGLE_W-1:0] min_angle [4];
  logic [ANGLE_W-1:0] max_angle [4];

  // servo position with its slot index and remainder kept alongside
  logic [ANGLE_W-1:0] pos;
  logic [ANGLE_W-1:0] pos_idx;
  logic [RW-1:0]      pos_rem;
  logic               sweep_up;

  logic [SLOT_COUNT-1:0] slot_valid;
  logic [SW-1:0]         cnt;
  logic                  rd_pend;
  logic [SW-1:0]         rd_idx;
  logic [RANGE_W-1:0]    rd_data;
  logic [RANGE_W-1:0]    rd_val;
  logic [RANGE_W-1:0]    best;
  logic [SW-1:0]         best_idx;

  logic                found;
  logic [ANGLE_W-1:0]  tgt_angle;
  logic [TRANGE_W-1:0] tgt_range;
  zone_t               zone;

  logic                out_valid;
  logic [ANGLE_W-1:0]  out_angle;
  logic                out_found;
  logic [ANGLE_W-1:0]  out_tangle;
  logic [TRANGE_W-1:0] out_trange;
  zone_t               out_zone;
  logic                out_up;

  logic                  accept;
  logic                  slot_hit;
  logic                  out_free;
  logic [TAW-1:0]        eval_angle;
  logic                  eval_found;
  zone_t                 eval_zone;
  logic [ANGLE_W-1:0]    wmin;
  logic [ANGLE_W-1:0]    wmax;
  logic [SLOT_COUNT-1:0] outside;

  assign accept   = range_in.valid && range_in.ready;
  assign range_in.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign slot_hit = (pos_rem == '0) && (pos_idx < ANGLE_W'(SLOT_COUNT));
  assign out_free = !out_valid || result_out.ready;

  srst_ram #(
    .WIDTH (RANGE_W),
    .DEPTH (SLOT_COUNT)
  ) u_slots (
    .clk   (clk),
    .we    (accept && slot_hit),
    .waddr (pos_idx[SW-1:0]),
    .wdata (range_in.range_cm),
    .raddr (cnt),
    .rdata (rd_data)
  );

  // a slot that was never written or has been cleared reads as no echo
  assign rd_val = slot_valid[rd_idx] ? rd_data : '0;

  always_comb begin
    eval_angle = TAW'(best_idx) * TAW'(ANGLE_STEP);
    eval_found = (best <= NEAR_LIMIT);
    eval_zone  = ZONE_FULL;
    if (eval_found && (best <= CLOSE_LIMIT)) begin
      if (eval_angle >= TAW'(LEFT_EDGE)) begin
        eval_zone = ZONE_LEFT;
      end else if (eval_angle <= TAW'(RIGHT_EDGE)) begin
        eval_zone = ZONE_RIGHT;
      end else begin
        eval_zone = ZONE_FRONT;
      end
    end
  end

  assign wmin = min_angle[zone];
  assign wmax = max_angle[zone];

  for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_win
    localparam logic [TAW-1:0] SLOT_ANGLE = TAW'(i * ANGLE_STEP);
    assign outside[i] = (SLOT_ANGLE < TAW'(wmin)) || (SLOT_ANGLE > TAW'(wmax));
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_angle[ZONE_FULL]  <= FULL_MIN_RST;
      max_angle[ZONE_FULL]  <= FULL_MAX_RST;
      min_angle[ZONE_LEFT]  <= LEFT_MIN_RST;
      max_angle[ZONE_LEFT]  <= LEFT_MAX_RST;
      min_angle[ZONE_RIGHT] <= RIGHT_MIN_RST;
      max_angle[ZONE_RIGHT] <= RIGHT_MAX_RST;
      min_angle[ZONE_FRONT] <= FRONT_MIN_RST;
      max_angle[ZONE_FRONT] <= FRONT_MAX_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_FULL_MIN:  min_angle[ZONE_FULL]  <= cfg.data;
        REG_FULL_MAX:  max_angle[ZONE_FULL]  <= cfg.data;
        REG_LEFT_MIN:  min_angle[ZONE_LEFT]  <= cfg.data;
        REG_LEFT_MAX:  max_angle[ZONE_LEFT]  <= cfg.data;
        REG_RIGHT_MIN: min_angle[ZONE_RIGHT] <= cfg.data;
        REG_RIGHT_MAX: max_angle[ZONE_RIGHT] <= cfg.data;
        REG_FRONT_MIN: min_angle[ZONE_FRONT] <= cfg.data;
        REG_FRONT_MAX: max_angle[ZONE_FRONT] <= cfg.data;
        default: ;
      endcase
    end
  end

  // control and scan datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      pos        <= ANGLE_W'(HOME_ANGLE);
      pos_idx    <= IDX_HOME;
      pos_rem    <= REM_HOME;
      sweep_up   <= 1'b0;
      rd_pend    <= 1'b0;
      out_valid  <= 1'b0;
      cnt        <= '0;
    end else begin
      rd_pend <= (state == S_SCAN);
      if ((state == S_MOVE) && out_free) begin
        out_valid <= 1'b1;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
      if (rd_pend && (rd_val != '0) && (rd_val < best)) begin
        best     <= rd_val;
        best_idx <= rd_idx;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (slot_hit) begin
              slot_valid[pos_idx[SW-1:0]] <= 1'b1;
            end
            best     <= NO_READING;
            best_idx <= '0;
            cnt      <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_idx <= cnt;
          if (cnt == SW'(SLOT_COUNT - 1)) begin
            state <= S_LAST;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        S_LAST: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          found     <= eval_found;
          tgt_angle <= eval_found ? eval_angle[ANGLE_W-1:0] : '0;
          tgt_range <= eval_found ? best[TRANGE_W-1:0] : '0;
          zone      <= eval_zone;
          state     <= S_MOVE;
        end
        S_MOVE: begin
          if (out_free) begin
            slot_valid <= slot_valid & ~outside;
            if ((!sweep_up && (pos > wmin)) || (sweep_up && !(pos < wmax))) begin
              // step down
              pos       <= pos - 1'b1;
              out_angle <= pos - 1'b1;
              sweep_up  <= 1'b0;
              out_up    <= 1'b0;
              // angle wraps from zero to the top of its range
              if (pos == '0) begin
                pos_rem <= REM_TOP;
                pos_idx <= IDX_TOP;
              end else if (pos_rem == '0) begin
                pos_rem <= REM_LAST;
                pos_idx <= pos_idx - 1'b1;
              end else begin
                pos_rem <= pos_rem - 1'b1;
              end
            end else begin
              pos       <= pos + 1'b1;
              out_angle <= pos + 1'b1;
              sweep_up  <= 1'b1;
              out_up    <= 1'b1;
              // angle wraps from the top of its range to zero
              if (pos == '1) begin
                pos_rem <= '0;
                pos_idx <= '0;
              end else if (pos_rem == REM_LAST) begin
                pos_rem <= '0;
                pos_idx <= pos_idx + 1'b1;
              end else begin
                pos_rem <= pos_rem + 1'b1;
              end
            end
            out_found  <= found;
            out_tangle <= tgt_angle;
            out_trange <= tgt_range;
            out_zone   <= zone;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign result_out.valid        = out_valid;
  assign result_out.servo_angle  = out_angle;
  assign result_out.target_found = out_found;
  assign result_out.target_angle = out_tangle;
  assign result_out.target_range = out_trange;
  assign result_out.zone_code    = out_zone;
  assign result_out.sweep_up     = out_up;

  // a missing target carries no angle or range
  a_no_target_clean: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && !result_out.target_found |->
      result_out.target_angle == '0 && result_out.target_range == '0)
    else $error("result without target carries angle or range");

  // a narrowed window needs a close target
  a_zone_needs_close: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.zone_code != ZONE_FULL |->
      result_out.target_found && result_out.target_range <= TRANGE_W'(CLOSE_LIMIT))
    else $error("narrowed window without close target");

  // a reported target is a real echo within the near limit
  a_target_range: assert property (@(posedge clk) disable iff (rst)
    result_out.valid && result_out.target_found |->
      result_out.target_range != '0 && result_out.target_range <= TRANGE_W'(NEAR_LIMIT))
    else $error("reported target range out of bounds");

  // the remainder tracker stays within one step
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    pos_rem <= REM_LAST)
    else $error("angle remainder out of range");

  // an accepted transaction occupies the scan before the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !range_in.ready ##1 !range_in.ready)
    else $error("reading taken during scan");

endmodule

[tb/sweeping_range_scan_tracker_checker.sv]
// ----------------------------------------------------------------------------
// sweeping_range_scan_tracker_checker
// Watches the range, result and register channels of the tracker, keeps its
// own copy of the slot store, sweep state and window bounds, predicts one
// result per accepted reading and compares the results in order.
// ----------------------------------------------------------------------------
module sweeping_range_scan_tracker_checker #(
  parameter int ANGLE_STEP = srst_pkg::ANGLE_STEP_DEF,
  parameter int SLOT_COUNT = srst_pkg::SLOT_COUNT_DEF
) (
  input  logic   clk,
  input  logic   rst,
  srst_range_if  range_mon,
  srst_result_if result_mon,
  srst_cfg_if    cfg_mon,
  output int     fail_count,
  output int     pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import srst_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [ANGLE_W-1:0]  servo_angle;
    logic                target_found;
    logic [ANGLE_W-1:0]  target_angle;
    logic [TRANGE_W-1:0] target_range;
    zone_t               zone_code;
    logic                sweep_up;
  } tracker_result_t;

  logic [RANGE_W-1:0] slot_range [SLOT_COUNT];
  logic [ANGLE_W-1:0] cur_angle;
  logic               sweeping_up;
  zone_t              cur_zone;
  logic [ANGLE_W-1:0] zone_lo [4];
  logic [ANGLE_W-1:0] zone_hi [4];

  tracker_result_t expected_results [$];

  task automatic reset_tracker_model();
    foreach (slot_range[i]) slot_range[i] = '0;
    cur_angle   = ANGLE_W'(HOME_ANGLE);
    sweeping_up = 1'b0;
    cur_zone    = ZONE_FULL;
    zone_lo[ZONE_FULL]  = FULL_MIN_RST;
    zone_hi[ZONE_FULL]  = FULL_MAX_RST;
    zone_lo[ZONE_LEFT]  = LEFT_MIN_RST;
    zone_hi[ZONE_LEFT]  = LEFT_MAX_RST;
    zone_lo[ZONE_RIGHT] = RIGHT_MIN_RST;
    zone_hi[ZONE_RIGHT] = RIGHT_MAX_RST;
    zone_lo[ZONE_FRONT] = FRONT_MIN_RST;
    zone_hi[ZONE_FRONT] = FRONT_MAX_RST;
  endtask

  // indexes past the last register leave the bounds alone
  task automatic write_window_bound(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    unique case (idx)
      REG_FULL_MIN:  zone_lo[ZONE_FULL]  = val;
      REG_FULL_MAX:  zone_hi[ZONE_FULL]  = val;
      REG_LEFT_MIN:  zone_lo[ZONE_LEFT]  = val;
      REG_LEFT_MAX:  zone_hi[ZONE_LEFT]  = val;
      REG_RIGHT_MIN: zone_lo[ZONE_RIGHT] = val;
      REG_RIGHT_MAX: zone_hi[ZONE_RIGHT] = val;
      REG_FRONT_MIN: zone_lo[ZONE_FRONT] = val;
      REG_FRONT_MAX: zone_hi[ZONE_FRONT] = val;
      default: ;
    endcase
  endtask

  function automatic tracker_result_t predict_scan_step(input logic [RANGE_W-1:0] reading);
    tracker_result_t r;
    int unsigned pos;
    int unsigned nearest;
    int unsigned nearest_idx;
    int unsigned t_angle;
    int unsigned wmin;
    int unsigned wmax;
    bit have;
    r           = '0;
    pos         = cur_angle;
    nearest     = NO_READING;
    nearest_idx = 0;
    have        = 1'b0;

    if (pos % ANGLE_STEP == 0 && pos / ANGLE_STEP < SLOT_COUNT)
      slot_range[pos / ANGLE_STEP] = reading;

    // first hit wins on a tie, so strictly-less keeps the lowest slot
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (slot_range[i] != 0 && slot_range[i] < nearest) begin
        nearest     = slot_range[i];
        nearest_idx = i;
        have        = 1'b1;
      end
    end

    cur_zone = ZONE_FULL;
    if (have && nearest <= NEAR_LIMIT) begin
      t_angle          = nearest_idx * ANGLE_STEP;
      r.target_found   = 1'b1;
      r.target_angle   = t_angle[ANGLE_W-1:0];
      r.target_range   = nearest[TRANGE_W-1:0];
      if (nearest <= CLOSE_LIMIT) begin
        if (t_angle >= LEFT_EDGE)       cur_zone = ZONE_LEFT;
        else if (t_angle <= RIGHT_EDGE) cur_zone = ZONE_RIGHT;
        else                            cur_zone = ZONE_FRONT;
      end
    end

    wmin = zone_lo[cur_zone];
    wmax = zone_hi[cur_zone];
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (i * ANGLE_STEP < wmin || i * ANGLE_STEP > wmax) slot_range[i] = '0;
    end

    // reversal at a window edge, bounds taken as given even when crossed
    if (!sweeping_up) begin
      if (pos > wmin) begin
        pos = pos - 1;
      end else begin
        sweeping_up = 1'b1;
        pos = pos + 1;
      end
    end else begin
      if (pos < wmax) begin
        pos = pos + 1;
      end else begin
        sweeping_up = 1'b0;
        pos = pos - 1;
      end
    end
    cur_angle = pos[ANGLE_W-1:0];

    r.servo_angle = cur_angle;
    r.zone_code   = cur_zone;
    r.sweep_up    = sweeping_up;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input tracker_result_t exp_r,
                                 input tracker_result_t got_r);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) begin
      $display("%0t %s: expected angle=%0d found=%0d t_angle=%0d t_range=%0d zone=%0d up=%0d",
               $time, what, exp_r.servo_angle, exp_r.target_found, exp_r.target_angle,
               exp_r.target_range, exp_r.zone_code, exp_r.sweep_up);
      $display("%0t %s: actual   angle=%0d found=%0d t_angle=%0d t_range=%0d zone=%0d up=%0d",
               $time, what, got_r.servo_angle, got_r.target_found, got_r.target_angle,
               got_r.target_range, got_r.zone_code, got_r.sweep_up);
    end
  endtask

  always @(posedge clk) begin : monitor
    tracker_result_t exp_r;
    tracker_result_t got_r;
    if (rst) begin
      reset_tracker_model();
      expected_results.delete();
      fail_count = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) write_window_bound(cfg_mon.index, cfg_mon.data);

      if (result_mon.valid && result_mon.ready) begin
        got_r.servo_angle  = result_mon.servo_angle;
        got_r.target_found = result_mon.target_found;
        got_r.target_angle = result_mon.target_angle;
        got_r.target_range = result_mon.target_range;
        got_r.zone_code    = zone_t'(result_mon.zone_code);
        got_r.sweep_up     = result_mon.sweep_up;
        if (expected_results.size() == 0) begin
          report_mismatch("result with no reading behind it", '0, got_r);
        end else begin
          exp_r = expected_results.pop_front();
          if (exp_r.servo_angle  !== got_r.servo_angle  ||
              exp_r.target_found !== got_r.target_found ||
              exp_r.target_angle !== got_r.target_angle ||
              exp_r.target_range !== got_r.target_range ||
              exp_r.zone_code    !== got_r.zone_code    ||
              exp_r.sweep_up     !== got_r.sweep_up)
            report_mismatch("result mismatch", exp_r, got_r);
        end
      end

      if (range_mon.valid && range_mon.ready)
        expected_results.push_back(predict_scan_step(range_mon.range_cm));
    end
    pending = expected_results.size();
  end

endmodule

[tb/sweeping_range_scan_tracker_top_tb.sv]
// ----------------------------------------------------------------------------
// sweeping_range_scan_tracker_top_tb
// Drives range readings and window bound writes into the tracker, with
// random gaps on both sides, and leaves prediction and comparison to the
// checker beside it. A directed run of boundary readings comes first, then
// random readings under several window settings, crossed and out-of-range
// bounds among them.
// ----------------------------------------------------------------------------
module sweeping_range_scan_tracker_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import srst_pkg::*;

  localparam int NUM_DIRECTED     = 24;
  localparam int NUM_PHASES       = 6;
  localparam int RANDOM_PER_PHASE = 155;
  localparam int TOTAL_READINGS   = NUM_DIRECTED + NUM_PHASES * RANDOM_PER_PHASE;
  localparam int CYCLE_LIMIT      = 400000;
  localparam int DRAIN_CYCLES     = SLOT_COUNT_DEF + 8;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = REG_FRONT_MAX + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;
  localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
    REG_FULL_MIN, REG_FULL_MAX, REG_LEFT_MIN, REG_LEFT_MAX,
    REG_RIGHT_MIN, REG_RIGHT_MAX, REG_FRONT_MIN, REG_FRONT_MAX
  };

  // start at 90 and sweep down: slots hit on the first, 11th and 21st readings
  localparam logic [RANGE_W-1:0] DIRECTED_READINGS [NUM_DIRECTED] = '{
    8'd15, 8'd0, 8'd255, 8'd1, 8'd254, 8'd20, 8'd21, 8'd50, 8'd51, 8'd128,
    8'd255, 8'd127, 8'd64, 8'd32, 8'd16, 8'd8, 8'd4, 8'd2, 8'd200, 8'd100,
    8'd1, 8'd0, 8'd255, 8'd50
  };

  logic clk;
  logic rst;
  logic rx_ready = 1'b0;
  int   tx_idle_pct = 0;
  int   rx_idle_pct = 0;
  int   readings_sent = 0;
  int   cycle_count = 0;
  int   fail_count;
  int   pending;
  logic [ANGLE_W-1:0] bank [8];

  srst_range_if  range_ch ();
  srst_result_if result_ch ();
  srst_cfg_if    cfg_ch ();

  assign result_ch.ready = rx_ready;

  sweeping_range_scan_tracker_top dut (
    .clk        (clk),
    .rst        (rst),
    .range_in   (range_ch),
    .result_out (result_ch),
    .cfg        (cfg_ch)
  );

  sweeping_range_scan_tracker_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .range_mon  (range_ch),
    .result_mon (result_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    rx_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver-heavy gaps, then sender-heavy, then none
  task automatic set_idling();
    if (readings_sent < TOTAL_READINGS / 3) begin
      tx_idle_pct = 35;
      rx_idle_pct = 60;
    end else if (readings_sent < 2 * TOTAL_READINGS / 3) begin
      tx_idle_pct = 60;
      rx_idle_pct = 35;
    end else begin
      tx_idle_pct = 0;
      rx_idle_pct = 0;
    end
  endtask

  function automatic logic [RANGE_W-1:0] random_reading();
    int sel;
    sel = $urandom_range(99);
    if (sel < 15)      return '0;
    else if (sel < 20) return NO_READING;
    else if (sel < 40) return RANGE_W'($urandom_range(1, 20));
    else if (sel < 60) return RANGE_W'($urandom_range(21, 50));
    else               return RANGE_W'($urandom_range(51, 254));
  endfunction

  // valid stays high after the transaction; the caller lowers it
  task automatic send_reading(input logic [RANGE_W-1:0] r);
    set_idling();
    while ($urandom_range(99) < tx_idle_pct) begin
      range_ch.valid <= 1'b0;
      @(posedge clk);
    end
    range_ch.valid    <= 1'b1;
    range_ch.range_cm <= r;
    do @(posedge clk); while (!range_ch.ready);
    readings_sent++;
  endtask

  task automatic wait_drained();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic load_bank(input int phase);
    case (phase)
      1: bank = '{8'd0, 8'd255, 8'd150, 8'd255, 8'd0, 8'd30, 8'd30, 8'd150};
      // crossed and collapsed windows
      2: bank = '{8'd200, 8'd10, 8'd180, 8'd180, 8'd0, 8'd0, 8'd90, 8'd90};
      3: begin
        foreach (bank[i])
          bank[i] = $urandom_range(1) ? ANGLE_W'($urandom_range(180))
                                      : ANGLE_W'($urandom_range(255));
      end
      4: bank = '{8'd20, 8'd160, 8'd100, 8'd170, 8'd10, 8'd80, 8'd40, 8'd140};
      default: bank = '{FULL_MIN_RST, FULL_MAX_RST, LEFT_MIN_RST, LEFT_MAX_RST,
                        RIGHT_MIN_RST, RIGHT_MAX_RST, FRONT_MIN_RST, FRONT_MAX_RST};
    endcase
  endtask

  // writes past the last register go out too and must change nothing
  task automatic write_bank();
    foreach (bank[i]) begin
      cfg_ch.valid <= 1'b1;
      cfg_ch.index <= REG_ORDER[i];
      cfg_ch.data  <= bank[i];
      do @(posedge clk); while (!cfg_ch.ready);
    end
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= REG_SPARE_FIRST;
    cfg_ch.data  <= ANGLE_W'($urandom_range(255));
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= REG_SPARE_LAST;
    cfg_ch.data  <= ANGLE_W'($urandom_range(255));
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    rst               <= 1'b1;
    range_ch.valid    <= 1'b0;
    range_ch.range_cm <= '0;
    cfg_ch.valid      <= 1'b0;
    cfg_ch.index      <= REG_FULL_MIN;
    cfg_ch.data       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_READINGS[i]) send_reading(DIRECTED_READINGS[i]);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        load_bank(phase);
        write_bank();
      end
      repeat (RANDOM_PER_PHASE) send_reading(random_reading());
      range_ch.valid <= 1'b0;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sweeping_range_scan_tracker_top.f]
sv/srst_pkg.sv
sv/srst_if.sv
sv/srst_ram.sv
sv/sweeping_range_scan_tracker_top.sv
tb/sweeping_range_scan_tracker_checker.sv
tb/sweeping_range_scan_tracker_top_tb.sv
